// ----- rtl/core/multi_compare_timer_peripheral_top_macros.svh -----
// Assertion macros for the checker file of the timer block.
`ifndef MULTI_COMPARE_TIMER_PERIPHERAL_TOP_MACROS_SVH
`define MULTI_COMPARE_TIMER_PERIPHERAL_TOP_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define MCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define MCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define MCT_ASSERT_ANY_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/mct_pkg.sv -----
// Package with the item types, codes and constants of the compare-match timer.
package mct_pkg;

    localparam int NUM_TIMERS_DEF = 8;
    localparam int MAX_CH         = 8;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [4:0] ADDR_CTRL    = 5'd0;
    localparam logic [4:0] ADDR_STATUS  = 5'd1;
    localparam logic [4:0] ADDR_INIT    = 5'd2;
    localparam logic [4:0] ADDR_NOW_SEC = 5'd3;
    localparam logic [4:0] ADDR_NOW_US  = 5'd4;
    localparam logic [4:0] ADDR_TRIG_LO = 5'd8;
    localparam logic [4:0] ADDR_TRIG_HI = 5'd23;

    localparam int ACTIVE_SHIFT = 16;
    localparam int IE_SHIFT     = 24;
    localparam int FLAG_SHIFT   = 24;

    localparam logic [19:0] MICROS_MAX   = 20'd999999;
    localparam logic [31:0] MICROS_MAX32 = 32'd999999;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  addr;
        logic [31:0] wdata;
    } t_in_item;

    typedef struct packed {
        logic [31:0] rdata;
        logic        irq;
    } t_out_item;

endpackage

// ----- rtl/core/mct_compare.sv -----
// Parallel comparators: which active channels have a trigger time below the clock.
module mct_compare #(
    parameter int NUM_TIMERS = mct_pkg::NUM_TIMERS_DEF
) (
    input  logic [31:0]           i_now_sec,
    input  logic [19:0]           i_now_us,
    input  logic [31:0]           i_trig_sec [NUM_TIMERS],
    input  logic [19:0]           i_trig_us  [NUM_TIMERS],
    input  logic [NUM_TIMERS-1:0] i_active,
    output logic [NUM_TIMERS-1:0] o_fire
);

    always_comb begin
        for (int ch = 0; ch < NUM_TIMERS; ch++) begin
            o_fire[ch] = i_active[ch] &&
                         ((i_now_sec > i_trig_sec[ch]) ||
                          (i_now_sec == i_trig_sec[ch] && i_now_us > i_trig_us[ch]));
        end
    end

endmodule

// ----- rtl/core/mct_regs.sv -----
// Register file and clock state of the timer; executes one item per enabled cycle.
module mct_regs #(
    parameter int NUM_TIMERS = mct_pkg::NUM_TIMERS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_exec,
    input  mct_pkg::t_in_item i_item,
    output mct_pkg::t_out_item o_result
);

    logic [31:0] r_ctrl, n_ctrl;
    logic [7:0]  r_flags, n_flags;
    logic [31:0] r_init, n_init;
    logic [31:0] r_now_sec, n_now_sec;
    logic [19:0] r_now_us, n_now_us;
    logic [19:0] r_latch_us, n_latch_us;
    logic        r_running, n_running;
    logic [31:0] r_trig_sec [NUM_TIMERS];
    logic [19:0] r_trig_us  [NUM_TIMERS];

    logic [31:0]           tick_sec;
    logic [19:0]           tick_us;
    logic [NUM_TIMERS-1:0] fire;
    logic [4:0]            trig_off;
    logic [2:0]            trig_ch;
    logic                  trig_wr;
    logic [19:0]           clamped_us;
    logic [31:0]           rdata;

    // Clock value after one microsecond; only used by ticks.
    assign tick_us  = (r_now_us == mct_pkg::MICROS_MAX) ? 20'd0 : r_now_us + 20'd1;
    assign tick_sec = (r_now_us == mct_pkg::MICROS_MAX) ? r_now_sec + 32'd1 : r_now_sec;

    assign trig_off   = i_item.addr - mct_pkg::ADDR_TRIG_LO;
    assign trig_ch    = trig_off[3:1];
    assign trig_wr    = i_exec && i_item.op == mct_pkg::OP_WRITE &&
                        i_item.addr >= mct_pkg::ADDR_TRIG_LO &&
                        i_item.addr <= mct_pkg::ADDR_TRIG_HI;
    assign clamped_us = (i_item.wdata > mct_pkg::MICROS_MAX32) ? mct_pkg::MICROS_MAX
                                                                 : i_item.wdata[19:0];

    mct_compare #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_compare (
        .i_now_sec  (tick_sec),
        .i_now_us   (tick_us),
        .i_trig_sec (r_trig_sec),
        .i_trig_us  (r_trig_us),
        .i_active   (r_ctrl[mct_pkg::ACTIVE_SHIFT +: NUM_TIMERS]),
        .o_fire     (fire)
    );

    always_comb begin
        n_ctrl     = r_ctrl;
        n_flags    = r_flags;
        n_init     = r_init;
        n_now_sec  = r_now_sec;
        n_now_us   = r_now_us;
        n_latch_us = r_latch_us;
        n_running  = r_running;
        rdata      = 32'd0;
        case (i_item.op)
            mct_pkg::OP_TICK: begin
                if (r_running) begin
                    n_now_us  = tick_us;
                    n_now_sec = tick_sec;
                    n_ctrl[mct_pkg::ACTIVE_SHIFT +: NUM_TIMERS] =
                        r_ctrl[mct_pkg::ACTIVE_SHIFT +: NUM_TIMERS] & ~fire;
                    n_flags = r_flags | 8'(fire);
                end
            end
            mct_pkg::OP_READ: begin
                unique case (i_item.addr) inside
                    mct_pkg::ADDR_CTRL:    rdata = r_ctrl;
                    mct_pkg::ADDR_STATUS:  rdata = {r_flags, 24'd0};
                    mct_pkg::ADDR_INIT:    rdata = r_init;
                    mct_pkg::ADDR_NOW_SEC: begin
                        rdata      = r_now_sec;
                        n_latch_us = r_now_us;
                    end
                    mct_pkg::ADDR_NOW_US:  rdata = 32'(r_latch_us);
                    [mct_pkg::ADDR_TRIG_LO:mct_pkg::ADDR_TRIG_HI]: begin
                        for (int ch = 0; ch < NUM_TIMERS; ch++) begin
                            if (trig_ch == 3'(ch)) begin
                                rdata = i_item.addr[0] ? 32'(r_trig_us[ch]) : r_trig_sec[ch];
                            end
                        end
                    end
                    default: rdata = 32'd0;
                endcase
            end
            mct_pkg::OP_WRITE: begin
                unique case (i_item.addr)
                    mct_pkg::ADDR_CTRL: begin
                        // Start loads the clock and is never stored.
                        if (i_item.wdata[0]) begin
                            n_running = 1'b1;
                            n_now_sec = r_init;
                            n_now_us  = 20'd0;
                        end
                        n_ctrl = {i_item.wdata[31:1], 1'b0};
                    end
                    mct_pkg::ADDR_STATUS: n_flags = r_flags & ~i_item.wdata[31:mct_pkg::FLAG_SHIFT];
                    mct_pkg::ADDR_INIT:   n_init  = i_item.wdata;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl     <= 32'd0;
            r_flags    <= 8'd0;
            r_init     <= 32'd0;
            r_now_sec  <= 32'd0;
            r_now_us   <= 20'd0;
            r_latch_us <= 20'd0;
            r_running  <= 1'b0;
        end else if (i_exec) begin
            r_ctrl     <= n_ctrl;
            r_flags    <= n_flags;
            r_init     <= n_init;
            r_now_sec  <= n_now_sec;
            r_now_us   <= n_now_us;
            r_latch_us <= n_latch_us;
            r_running  <= n_running;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int ch = 0; ch < NUM_TIMERS; ch++) begin
                r_trig_sec[ch] <= 32'd0;
                r_trig_us[ch]  <= 20'd0;
            end
        end else if (trig_wr) begin
            for (int ch = 0; ch < NUM_TIMERS; ch++) begin
                if (trig_ch == 3'(ch)) begin
                    if (i_item.addr[0]) begin
                        r_trig_us[ch] <= clamped_us;
                    end else begin
                        r_trig_sec[ch] <= i_item.wdata;
                    end
                end
            end
        end
    end

    assign o_result.rdata = rdata;
    assign o_result.irq   = |(n_flags & n_ctrl[mct_pkg::IE_SHIFT +: 8]);

endmodule

// ----- rtl/core/multi_compare_timer_peripheral_top.sv -----
// Top level of the eight-channel compare-match timer with its item pipeline.
//
// Input channel: i_in_valid / o_in_stall carry one item (op, addr, wdata):
// a microsecond tick, a bus read or a bus write. Output channel:
// o_out_valid / i_out_stall carry one result (rdata, irq) per item, in order.
// An item is registered at acceptance and executed against the timer state
// once the output register is free or being emptied, with its result captured
// in the output register, from which the receiver takes it.
// Throughput is one item per cycle while the receiver does not stall: the
// input register refills while the output register is emptied, and a register
// update with eight parallel comparators handles ticks and bus accesses alike.
// When the receiver stalls, the result holds in the output register and one
// more item waits in the input register; only then does o_in_stall rise.
// Reset (i_rst_n low at a clock edge) empties both registers, clears all
// timer registers and stops the clock. irq reflects the state after the item.
module multi_compare_timer_peripheral_top #(
    parameter int NUM_TIMERS = mct_pkg::NUM_TIMERS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mct_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mct_pkg::t_out_item o_out_data
);

    logic               r_in_valid;
    mct_pkg::t_in_item  r_in_data;
    logic               r_out_valid;
    mct_pkg::t_out_item r_out_data;
    mct_pkg::t_out_item result;
    logic               advance;
    logic               in_accept;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    mct_regs #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_exec   (advance),
        .i_item   (r_in_data),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/core/mct_checker.sv -----
// Port-level checker for the timer top level and its bind statement.
`include "multi_compare_timer_peripheral_top_macros.svh"

module mct_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input mct_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mct_pkg::t_out_item o_out_data
);

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall && (i_in_data.op == i_in_data.op);

    // The input side only backs up when a result is blocked downstream.
    `MCT_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    // Every accepted item is followed by a valid result at the output.
    `MCT_ASSERT_NXT(a_result_due, i_clk, i_rst_n, in_acc, ##1 o_out_valid)
    // A result held by the receiver does not change.
    `MCT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_data))
    // Reset leaves no result pending.
    `MCT_ASSERT_ANY_NXT(a_reset_empty, i_clk, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind multi_compare_timer_peripheral_top mct_checker u_mct_checker (.*);
